// ----- design/pdfq_pkg.sv -----
// pdfq_pkg: shared types, constants and helpers for the packet descriptor queue.
// Used by pdfq_store and packet_descriptor_fifo_with_serial; no dependencies.
`timescale 1ns / 1ps

package pdfq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 24;
  localparam int DUR_W    = 32;
  localparam int DTS_W    = 48;
  localparam int STREAM_W = 4;
  localparam int SERIAL_W = 16;
  localparam int BYTES_W  = 32;
  localparam int DTOT_W   = 38;
  localparam int OVH_W    = 8;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_MARKER = 3'd1,
    OP_GET    = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_ABORT  = 3'd4,
    OP_START  = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABORTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One queued descriptor
  typedef struct packed {
    logic                       marker;
    logic [STREAM_W-1:0]        stream;
    logic [SERIAL_W-1:0]        serial;
    logic [HANDLE_W-1:0]        handle;
    logic [SIZE_W-1:0]          size;
    logic [DUR_W-1:0]           duration;
    logic signed [DTS_W-1:0]    dts;
  } entry_t;

  // Request from the queue control to the descriptor store
  typedef struct packed {
    logic   wr_en;
    ptr_t   wr_addr;
    entry_t wr_data;
    ptr_t   rd_addr;
  } store_req_t;

  // Step a ring pointer, wrapping at the queue depth
  function automatic ptr_t ptr_advance(input ptr_t p);
    ptr_t r;
    if (CNT_W'(p) + CNT_W'(1) >= CNT_W'(QUEUE_DEPTH)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- design/pdfq_store.sv -----
// pdfq_store: descriptor memory of the queue with one write and one registered read.
// A write to the address being read in the same cycle is forwarded. Depends on pdfq_pkg.
`timescale 1ns / 1ps

module pdfq_store (
  input  logic                clk,
  input  pdfq_pkg::store_req_t req,
  output pdfq_pkg::entry_t    rd_data
);
  import pdfq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  // Write the tail slot
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read with write-first forwarding
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/packet_descriptor_fifo_with_serial.sv -----
// packet_descriptor_fifo_with_serial: bounded descriptor queue with playback serial.
// An accepted transaction's result is registered once the result register is free.
// Throughput: one transaction per cycle unless out_ready stalls; the head entry and the
// one behind it sit in registers, the second refilled each cycle from the single-read store.
// Reset (synchronous, rst_n low): queue empty, serial zero, abort flag set, overhead zero.
// Depends on pdfq_pkg and pdfq_store.
`timescale 1ns / 1ps

module packet_descriptor_fifo_with_serial (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_operation,
  input  logic [pdfq_pkg::HANDLE_W-1:0]        in_buf_handle,
  input  logic [pdfq_pkg::SIZE_W-1:0]          in_pkt_size,
  input  logic [pdfq_pkg::DUR_W-1:0]           in_pkt_duration,
  input  logic signed [pdfq_pkg::DTS_W-1:0]    in_pkt_dts,
  input  logic [pdfq_pkg::STREAM_W-1:0]        in_stream_number,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [pdfq_pkg::HANDLE_W-1:0]        out_handle,
  output logic [pdfq_pkg::SIZE_W-1:0]          out_size,
  output logic [pdfq_pkg::DUR_W-1:0]           out_duration,
  output logic signed [pdfq_pkg::DTS_W-1:0]    out_dts,
  output logic [pdfq_pkg::STREAM_W-1:0]        out_stream,
  output logic [pdfq_pkg::SERIAL_W-1:0]        out_serial,
  output logic                                 out_is_marker,
  output logic [6:0]                           out_queued_count,
  output logic [pdfq_pkg::BYTES_W-1:0]         out_queued_bytes,
  output logic [pdfq_pkg::DTOT_W-1:0]          out_queued_duration,
  output logic signed [pdfq_pkg::DTS_W-1:0]    out_dts_span,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import pdfq_pkg::*;

  // Configuration register
  logic [OVH_W-1:0] ovh_r;

  // Input register
  logic                      iv_r;
  logic [2:0]                op_r;
  logic [HANDLE_W-1:0]       handle_r;
  logic [SIZE_W-1:0]         size_r;
  logic [DUR_W-1:0]          dur_r;
  logic signed [DTS_W-1:0]   dts_r;
  logic [STREAM_W-1:0]       stream_r;

  // Queue state
  ptr_t                  head_r, head_nxt;
  ptr_t                  tail_r, tail_nxt;
  cnt_t                  count_r, count_nxt;
  logic [BYTES_W-1:0]    bytes_r, bytes_nxt;
  logic [DTOT_W-1:0]     dtot_r, dtot_nxt;
  logic [SERIAL_W-1:0]   serial_r, serial_nxt;
  logic                  abort_r, abort_nxt;
  entry_t                hd_r, hd_nxt;
  logic signed [DTS_W-1:0] last_dts_r, last_dts_nxt;

  // Result register
  logic                    ov_r;
  status_t                 res_status_r, res_status_nxt;
  entry_t                  res_ent_r, res_ent_nxt;
  cnt_t                    res_count_r;
  logic [BYTES_W-1:0]      res_bytes_r;
  logic [DTOT_W-1:0]       res_dtot_r;
  logic signed [DTS_W-1:0] res_span_r, res_span_nxt;

  logic       proc;
  logic       enq;
  logic       enq_marker;
  logic       deq;
  logic       full;
  entry_t     new_ent;
  entry_t     nh_data;
  store_req_t store_req;

  // Process the held transaction when the result register is free
  assign proc     = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || proc;
  assign full     = (count_r == cnt_t'(QUEUE_DEPTH));

  // Configuration access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-OVH_W){1'b0}}, ovh_r} : 32'd0;

  // Decode the operation and work out the next queue state
  always_comb begin
    logic [SERIAL_W-1:0] serial_eff;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    dtot_nxt       = dtot_r;
    serial_nxt     = serial_r;
    abort_nxt      = abort_r;
    hd_nxt         = hd_r;
    last_dts_nxt   = last_dts_r;
    res_status_nxt = ST_OK;
    res_ent_nxt    = '0;
    enq            = 1'b0;
    enq_marker     = 1'b0;
    deq            = 1'b0;
    new_ent        = '0;
    serial_eff     = serial_r;

    if (proc) begin
      case (op_r)
        OP_PUT, OP_MARKER: begin
          if (abort_r) begin
            res_status_nxt = ST_ABORTED;
          end else if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            enq        = 1'b1;
            enq_marker = (op_r == OP_MARKER);
          end
        end
        OP_GET: begin
          if (abort_r) begin
            res_status_nxt = ST_ABORTED;
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            deq = 1'b1;
          end
        end
        OP_FLUSH: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          bytes_nxt = '0;
          dtot_nxt  = '0;
        end
        OP_ABORT: begin
          abort_nxt = 1'b1;
        end
        OP_START: begin
          abort_nxt = 1'b0;
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            enq        = 1'b1;
            enq_marker = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Enqueue at the tail, advancing the serial for a marker
      if (enq) begin
        serial_eff = enq_marker ? serial_r + SERIAL_W'(1) : serial_r;
        serial_nxt = serial_eff;
        if (enq_marker) begin
          new_ent.marker = 1'b1;
        end else begin
          new_ent.stream   = stream_r;
          new_ent.handle   = handle_r;
          new_ent.size     = size_r;
          new_ent.duration = dur_r;
          new_ent.dts      = dts_r;
        end
        new_ent.serial = serial_eff;
        tail_nxt     = ptr_advance(tail_r);
        count_nxt    = count_r + cnt_t'(1);
        bytes_nxt    = bytes_r + BYTES_W'(new_ent.size) + BYTES_W'(ovh_r);
        dtot_nxt     = dtot_r + DTOT_W'(new_ent.duration);
        last_dts_nxt = new_ent.dts;
        if (count_r == '0) begin
          hd_nxt = new_ent;
        end
      end

      // Dequeue the head and promote the entry behind it
      if (deq) begin
        res_ent_nxt = hd_r;
        head_nxt    = ptr_advance(head_r);
        count_nxt   = count_r - cnt_t'(1);
        bytes_nxt   = bytes_r - BYTES_W'(hd_r.size) - BYTES_W'(ovh_r);
        dtot_nxt    = dtot_r - DTOT_W'(hd_r.duration);
        hd_nxt      = nh_data;
      end
    end
  end

  // Span from newest to oldest entry after the transaction
  assign res_span_nxt = (count_nxt != '0) ? (last_dts_nxt - hd_nxt.dts) : '0;

  // Store writes the tail and prefetches the entry behind the next head
  always_comb begin
    store_req         = '0;
    store_req.wr_en   = enq;
    store_req.wr_addr = tail_r;
    store_req.wr_data = new_ent;
    store_req.rd_addr = ptr_advance(head_nxt);
  end

  pdfq_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (nh_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovh_r    <= '0;
      iv_r     <= 1'b0;
      ov_r     <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      bytes_r  <= '0;
      dtot_r   <= '0;
      serial_r <= '0;
      abort_r  <= 1'b1;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        ovh_r <= pwdata[OVH_W-1:0];
      end
      iv_r     <= (in_valid && in_ready) || (iv_r && !proc);
      ov_r     <= proc || (ov_r && !out_ready);
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      bytes_r  <= bytes_nxt;
      dtot_r   <= dtot_nxt;
      serial_r <= serial_nxt;
      abort_r  <= abort_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      handle_r <= in_buf_handle;
      size_r   <= in_pkt_size;
      dur_r    <= in_pkt_duration;
      dts_r    <= in_pkt_dts;
      stream_r <= in_stream_number;
    end
    hd_r       <= hd_nxt;
    last_dts_r <= last_dts_nxt;
    if (proc) begin
      res_status_r <= res_status_nxt;
      res_ent_r    <= res_ent_nxt;
      res_count_r  <= count_nxt;
      res_bytes_r  <= bytes_nxt;
      res_dtot_r   <= dtot_nxt;
      res_span_r   <= res_span_nxt;
    end
  end

  // Drive the result channel
  assign out_valid           = ov_r;
  assign out_status          = res_status_r;
  assign out_handle          = res_ent_r.handle;
  assign out_size            = res_ent_r.size;
  assign out_duration        = res_ent_r.duration;
  assign out_dts             = res_ent_r.dts;
  assign out_stream          = res_ent_r.stream;
  assign out_serial          = res_ent_r.serial;
  assign out_is_marker       = res_ent_r.marker;
  assign out_queued_count    = 7'(res_count_r);
  assign out_queued_bytes    = res_bytes_r;
  assign out_queued_duration = res_dtot_r;
  assign out_dts_span        = res_span_r;

endmodule

// ----- tb/sv/packet_descriptor_fifo_with_serial_tb.sv -----
// packet_descriptor_fifo_with_serial_tb: self-checking testbench for the descriptor queue.
// Predicts every result from a shadow copy of the queue; depends on pdfq_pkg and the RTL.
`timescale 1ns / 1ps

module packet_descriptor_fifo_with_serial_tb;
  import pdfq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 315;
  localparam logic [2:0] REG_ENTRY_OVERHEAD = 3'd0;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // Traffic mix for the random phases
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  typedef struct {
    logic [2:0]               op;
    logic [HANDLE_W-1:0]      handle;
    logic [SIZE_W-1:0]        size;
    logic [DUR_W-1:0]         duration;
    logic signed [DTS_W-1:0]  dts;
    logic [STREAM_W-1:0]      stream;
  } desc_op_t;

  typedef struct {
    logic [1:0]               status;
    logic [HANDLE_W-1:0]      handle;
    logic [SIZE_W-1:0]        size;
    logic [DUR_W-1:0]         duration;
    logic signed [DTS_W-1:0]  dts;
    logic [STREAM_W-1:0]      stream;
    logic [SERIAL_W-1:0]      serial;
    logic                     marker;
    logic [6:0]               count;
    logic [BYTES_W-1:0]       bytes;
    logic [DTOT_W-1:0]        dur_total;
    logic signed [DTS_W-1:0]  span;
  } queue_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [2:0]                    in_operation;
  logic [HANDLE_W-1:0]           in_buf_handle;
  logic [SIZE_W-1:0]             in_pkt_size;
  logic [DUR_W-1:0]              in_pkt_duration;
  logic signed [DTS_W-1:0]       in_pkt_dts;
  logic [STREAM_W-1:0]           in_stream_number;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_status;
  logic [HANDLE_W-1:0]           out_handle;
  logic [SIZE_W-1:0]             out_size;
  logic [DUR_W-1:0]              out_duration;
  logic signed [DTS_W-1:0]       out_dts;
  logic [STREAM_W-1:0]           out_stream;
  logic [SERIAL_W-1:0]           out_serial;
  logic                          out_is_marker;
  logic [6:0]                    out_queued_count;
  logic [BYTES_W-1:0]            out_queued_bytes;
  logic [DTOT_W-1:0]             out_queued_duration;
  logic signed [DTS_W-1:0]       out_dts_span;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // Shadow copy of the queue state
  entry_t              shadow_slots[QUEUE_DEPTH];
  int                  shadow_head;
  int                  shadow_tail;
  int                  shadow_count;
  logic [BYTES_W-1:0]  shadow_bytes;
  logic [DTOT_W-1:0]   shadow_duration;
  logic [SERIAL_W-1:0] shadow_serial;
  logic                shadow_abort;
  logic [OVH_W-1:0]    shadow_overhead;

  queue_result_t expected_results[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;

  packet_descriptor_fifo_with_serial u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_buf_handle       (in_buf_handle),
    .in_pkt_size         (in_pkt_size),
    .in_pkt_duration     (in_pkt_duration),
    .in_pkt_dts          (in_pkt_dts),
    .in_stream_number    (in_stream_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_handle          (out_handle),
    .out_size            (out_size),
    .out_duration        (out_duration),
    .out_dts             (out_dts),
    .out_stream          (out_stream),
    .out_serial          (out_serial),
    .out_is_marker       (out_is_marker),
    .out_queued_count    (out_queued_count),
    .out_queued_bytes    (out_queued_bytes),
    .out_queued_duration (out_queued_duration),
    .out_dts_span        (out_dts_span),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packet_descriptor_fifo_with_serial_tb: done, errors");
      $finish;
    end
  end

  // Append one entry at the tail; return the status of the attempt
  function automatic logic [1:0] shadow_enqueue(input desc_op_t d, input logic is_marker);
    entry_t e;
    if (shadow_abort) return ST_ABORTED;
    if (shadow_count >= QUEUE_DEPTH) return ST_FULL;
    e = '0;
    if (is_marker) begin
      shadow_serial = shadow_serial + SERIAL_W'(1);
      e.marker = 1'b1;
    end else begin
      e.handle = d.handle;
      e.size = d.size;
      e.duration = d.duration;
      e.dts = d.dts;
      e.stream = d.stream;
    end
    e.serial = shadow_serial;
    shadow_slots[shadow_tail] = e;
    shadow_tail = (shadow_tail + 1 >= QUEUE_DEPTH) ? 0 : shadow_tail + 1;
    shadow_count++;
    shadow_bytes = shadow_bytes + BYTES_W'(e.size) + BYTES_W'(shadow_overhead);
    shadow_duration = shadow_duration + DTOT_W'(e.duration);
    return ST_OK;
  endfunction

  // Apply one transaction to the shadow queue and build its result
  function automatic queue_result_t predict_descriptor_op(input desc_op_t d);
    queue_result_t r;
    entry_t e;
    int last;
    r = '{default: '0};
    case (d.op)
      OP_PUT: r.status = shadow_enqueue(d, 1'b0);
      OP_MARKER: r.status = shadow_enqueue(d, 1'b1);
      OP_GET: begin
        if (shadow_abort) begin
          r.status = ST_ABORTED;
        end else if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = shadow_slots[shadow_head];
          r.handle = e.handle;
          r.size = e.size;
          r.duration = e.duration;
          r.dts = e.dts;
          r.stream = e.stream;
          r.serial = e.serial;
          r.marker = e.marker;
          shadow_head = (shadow_head + 1 >= QUEUE_DEPTH) ? 0 : shadow_head + 1;
          shadow_count--;
          shadow_bytes = shadow_bytes - BYTES_W'(e.size) - BYTES_W'(shadow_overhead);
          shadow_duration = shadow_duration - DTOT_W'(e.duration);
        end
      end
      OP_FLUSH: begin
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
        shadow_bytes = '0;
        shadow_duration = '0;
      end
      OP_ABORT: shadow_abort = 1'b1;
      OP_START: begin
        shadow_abort = 1'b0;
        r.status = shadow_enqueue(d, 1'b1);
      end
      default: ;
    endcase
    r.count = 7'(shadow_count);
    r.bytes = shadow_bytes;
    r.dur_total = shadow_duration;
    if (shadow_count != 0) begin
      last = (shadow_tail == 0) ? QUEUE_DEPTH - 1 : shadow_tail - 1;
      r.span = shadow_slots[last].dts - shadow_slots[shadow_head].dts;
    end
    return r;
  endfunction

  // Build a transaction with random descriptor content
  function automatic desc_op_t make_op(input logic [2:0] op);
    desc_op_t d;
    d.op = op;
    d.handle = $urandom;
    d.size = SIZE_W'($urandom);
    d.duration = $urandom;
    d.dts = DTS_W'({$urandom, $urandom});
    d.stream = STREAM_W'($urandom);
    return d;
  endfunction

  // Drive one transaction and record its expected result on acceptance
  task automatic send_descriptor_op(input desc_op_t d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= d.op;
    in_buf_handle <= d.handle;
    in_pkt_size <= d.size;
    in_pkt_duration <= d.duration;
    in_pkt_dts <= d.dts;
    in_stream_number <= d.stream;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_descriptor_op(d));
  endtask

  // Hold the input idle until every outstanding result has been seen
  task automatic settle_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the per-entry overhead register through a setup and an access cycle
  task automatic write_entry_overhead(input logic [OVH_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ENTRY_OVERHEAD;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_overhead = value;
  endtask

  // Pick an operation for the random traffic, weighted by the current mix
  function automatic logic [2:0] pick_random_op(input traffic_mix_t mix);
    int r;
    int put_share;
    r = $urandom_range(0, 99);
    put_share = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 50;
    if (shadow_abort && r < 40) return OP_START;
    if (r < 1) return OP_ABORT;
    if (r < 2) return OP_FLUSH;
    if (r < 3) return ($urandom_range(0, 1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (r < 7) return OP_MARKER;
    if (r < 9) return OP_START;
    return ($urandom_range(0, 99) < put_share) ? OP_PUT : OP_GET;
  endfunction

  // Aborted state after reset, serial tagging, field extremes, unused codes
  task automatic test_abort_and_special_ops();
    desc_op_t d;
    write_entry_overhead(8'd0);
    send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_MARKER));
    send_descriptor_op(make_op(OP_START));
    d = make_op(OP_PUT);
    d.handle = '1;
    d.size = '1;
    d.duration = '1;
    d.dts = {1'b0, {(DTS_W-1){1'b1}}};
    d.stream = '1;
    send_descriptor_op(d);
    d.handle = '0;
    d.size = '0;
    d.duration = '0;
    d.dts = {1'b1, {(DTS_W-1){1'b0}}};
    d.stream = '0;
    send_descriptor_op(d);
    send_descriptor_op(make_op(OP_UNUSED_6));
    send_descriptor_op(make_op(OP_UNUSED_7));
    repeat (4) send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_MARKER));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_FLUSH));
    send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_ABORT));
    send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_FLUSH));
    send_descriptor_op(make_op(OP_START));
    send_descriptor_op(make_op(OP_GET));
    settle_results();
  endtask

  // Fill to capacity, push against the full queue, then drain it
  task automatic test_fill_to_full();
    write_entry_overhead(8'hFF);
    send_descriptor_op(make_op(OP_FLUSH));
    while (shadow_count < QUEUE_DEPTH) send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_MARKER));
    send_descriptor_op(make_op(OP_START));
    send_descriptor_op(make_op(OP_ABORT));
    send_descriptor_op(make_op(OP_PUT));
    send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_START));
    send_descriptor_op(make_op(OP_PUT));
    // hold the sender until the queue has answered everything
    settle_results();
    while (shadow_count > 0) send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_GET));
    settle_results();
  endtask

  // Change the overhead with entries held so the byte total wraps
  task automatic test_overhead_rewrite();
    write_entry_overhead(8'd0);
    send_descriptor_op(make_op(OP_FLUSH));
    repeat (4) send_descriptor_op(make_op(OP_PUT));
    settle_results();
    write_entry_overhead(8'hFF);
    repeat (2) send_descriptor_op(make_op(OP_PUT));
    repeat (6) send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_PUT));
    settle_results();
    write_entry_overhead(8'h80);
    repeat (2) send_descriptor_op(make_op(OP_GET));
    send_descriptor_op(make_op(OP_FLUSH));
    settle_results();
  endtask

  // Mixed random traffic in phases, overhead rewritten between phases
  task automatic test_random_traffic();
    traffic_mix_t mix;
    logic [OVH_W-1:0] ovh;
    mix = MIX_BALANCED;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: ovh = 8'hFF;
        2: ovh = 8'h00;
        default: ovh = OVH_W'($urandom);
      endcase
      write_entry_overhead(ovh);
      // run the last phase without any idling
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0) mix = traffic_mix_t'($urandom_range(0, 2));
        send_descriptor_op(make_op(pick_random_op(mix)));
      end
      settle_results();
    end
  endtask

  // Result side: stall in random bursts, none once the run turns calm
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] expv,
                             input logic [63:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    queue_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("out_handle", exp_r.handle, out_handle);
        check_field("out_size", exp_r.size, out_size);
        check_field("out_duration", exp_r.duration, out_duration);
        check_field("out_dts", exp_r.dts, out_dts);
        check_field("out_stream", exp_r.stream, out_stream);
        check_field("out_serial", exp_r.serial, out_serial);
        check_field("out_is_marker", exp_r.marker, out_is_marker);
        check_field("queued_count", exp_r.count, out_queued_count);
        check_field("queued_bytes", exp_r.bytes, out_queued_bytes);
        check_field("queued_duration", exp_r.dur_total, out_queued_duration);
        check_field("dts_span", exp_r.span, out_dts_span);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_PUT;
    in_buf_handle <= '0;
    in_pkt_size <= '0;
    in_pkt_duration <= '0;
    in_pkt_dts <= '0;
    in_stream_number <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_ENTRY_OVERHEAD;
    pwdata <= '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    shadow_bytes = '0;
    shadow_duration = '0;
    shadow_serial = '0;
    shadow_abort = 1'b1;
    shadow_overhead = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_abort_and_special_ops();
    test_fill_to_full();
    test_overhead_rewrite();
    test_random_traffic();

    settle_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("packet_descriptor_fifo_with_serial_tb: done, clean");
    end else begin
      $display("packet_descriptor_fifo_with_serial_tb: done, errors");
    end
    $finish;
  end

endmodule
